### hdl/fcw_pkg.sv
package fcw_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_START   = 2'd1,
		ACT_ADVANCE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_WRITE     = 3'd1,
		ST_HOP_LIMIT = 3'd2,
		ST_RANGE     = 3'd3,
		ST_NO_WALK   = 3'd4
	} status_t;

	localparam logic REG_ENTRIES = 1'b0;
	localparam logic REG_SHIFT   = 1'b1;

	localparam logic [31:0] END_MARK  = 32'hFFFF_FFFE;
	localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;

	localparam logic [4:0] SHIFT_MIN   = 5'd7;
	localparam logic [4:0] SHIFT_MAX   = 5'd16;
	localparam logic [4:0] SHIFT_RESET = 5'd9;

	localparam int ENTRIES_W = 13;
	localparam int HOP_W     = 14;

endpackage

### hdl/fat_chain_walker_top.sv
// Sector chain walker over a link table held in on-chip memory.
// Command channel: an item is taken at a rising edge with start high and busy
// low. action selects a table write (entry_index, entry_value), a walk start
// (start_sector, stream_length; zero length walks to the chain end) or one
// hop along the chain.
// Result channel: each result is on the result ports for one cycle, marked by
// strobe. A write or an advance gives one result; a start gives none.
// A write, or an advance that finds no walk, an empty chain or an
// error, shows its result in the cycle after it is taken. A normal hop reads
// the link of the cursor from the table memory at the accepting edge, then
// holds busy in S_HOP while it follows it; its result is registered as it
// leaves S_HOP, and the next item can be taken while that result is shown.
// No item is taken while a hop is busy, since the table memory read must
// finish before the cursor moves. Other items run at one per cycle unless busy.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 entries used, 1 sector
// shift) and cfg_data; cfg_ready is always high. Write it only while idle.
// Reset clears the cursor, walk state and output strobe and sets the sector
// shift to 9; table contents are undefined until written. The receiver cannot
// stall: a result is presented once and not held.
module fat_chain_walker_top
	import fcw_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096,
	parameter int HOP_SLACK   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [11:0]          entry_index,
	input  logic [31:0]          entry_value,
	input  logic [31:0]          start_sector,
	input  logic [47:0]          stream_length,
	output logic                 strobe,
	output logic [31:0]          sector_index,
	output logic [47:0]          byte_offset,
	output logic [16:0]          valid_bytes,
	output logic                 is_last,
	output logic [2:0]           status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [ENTRIES_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic {
		S_IDLE,
		S_HOP
	} state_t;

	state_t               state_q;
	logic [31:0]          link_table [TABLE_DEPTH];
	logic [31:0]          rd_q;

	logic [ENTRIES_W-1:0] entries_q;
	logic [4:0]           shift_q;
	logic [31:0]          cursor_q;
	logic [HOP_W-1:0]     hop_count_q;
	logic [47:0]          bytes_left_q;
	logic                 bounded_q;
	logic                 active_q;

	logic [31:0]          sec_s1;
	logic [47:0]          off_s1;
	logic [16:0]          valid_s1;

	logic                 strobe_q;
	logic [31:0]          sector_q;
	logic [47:0]          offset_q;
	logic [16:0]          valid_q;
	logic                 last_q;
	status_t              status_q;

	logic                 accept;
	logic                 mem_wr;
	logic [31:0]          widx;
	logic [ENTRIES_W-1:0] used_c;
	logic [4:0]           shift_c;
	logic [HOP_W-1:0]     hop_next;
	logic [HOP_W-1:0]     hop_limit;
	logic                 cur_marker;
	logic                 hop_err;
	logic                 range_err;
	logic [16:0]          size_c;
	logic [16:0]          valid_c;
	logic [47:0]          off_c;
	logic                 next_last;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q == S_HOP);
	assign cfg_ready = 1'b1;

	assign widx   = 32'(entry_index);
	assign mem_wr = accept && (action == ACT_WRITE) && (widx < 32'(TABLE_DEPTH));

	// clamp the entry count to the table and the shift to its legal range
	always_comb begin
		if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
			used_c = ENTRIES_W'(TABLE_DEPTH);
		end else begin
			used_c = entries_q;
		end
		if (shift_q < SHIFT_MIN) begin
			shift_c = SHIFT_MIN;
		end else if (shift_q > SHIFT_MAX) begin
			shift_c = SHIFT_MAX;
		end else begin
			shift_c = shift_q;
		end
	end

	assign hop_next   = hop_count_q + HOP_W'(1);
	assign hop_limit  = HOP_W'(used_c) + HOP_W'(HOP_SLACK);
	assign cur_marker = (cursor_q == END_MARK) || (cursor_q == FREE_MARK);
	assign hop_err    = hop_next > hop_limit;
	assign range_err  = cursor_q >= 32'(used_c);
	assign size_c     = 17'(1) << shift_c;
	assign off_c      = (48'(cursor_q) + 48'd1) << shift_c;
	assign next_last  = (rd_q == END_MARK) || (rd_q == FREE_MARK);

	always_comb begin
		if (!bounded_q) begin
			valid_c = size_c;
		end else if (bytes_left_q < 48'(size_c)) begin
			valid_c = bytes_left_q[16:0];
		end else begin
			valid_c = size_c;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			link_table[widx[AW-1:0]] <= entry_value;
		end
		rd_q <= link_table[cursor_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			shift_q   <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENTRIES: entries_q <= cfg_data;
				REG_SHIFT:   shift_q   <= cfg_data[4:0];
				default:     entries_q <= entries_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sec_s1   <= cursor_q;
			off_s1   <= off_c;
			valid_s1 <= valid_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cursor_q     <= '0;
			hop_count_q  <= '0;
			bytes_left_q <= '0;
			bounded_q    <= 1'b0;
			active_q     <= 1'b0;
			strobe_q     <= 1'b0;
			sector_q     <= '0;
			offset_q     <= '0;
			valid_q      <= '0;
			last_q       <= 1'b0;
			status_q     <= ST_OK;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_WRITE: begin
								strobe_q <= 1'b1;
								sector_q <= '0;
								offset_q <= '0;
								valid_q  <= '0;
								last_q   <= 1'b0;
								status_q <= ST_WRITE;
							end
							ACT_START: begin
								cursor_q     <= start_sector;
								bytes_left_q <= stream_length;
								bounded_q    <= (stream_length != '0);
								hop_count_q  <= '0;
								active_q     <= 1'b1;
							end
							ACT_ADVANCE: begin
								sector_q <= '0;
								offset_q <= '0;
								valid_q  <= '0;
								last_q   <= 1'b1;
								status_q <= ST_OK;
								if (!active_q) begin
									strobe_q <= 1'b1;
									status_q <= ST_NO_WALK;
								end else if (cur_marker) begin
									strobe_q <= 1'b1;
									active_q <= 1'b0;
								end else begin
									hop_count_q <= hop_next;
									if (hop_err) begin
										strobe_q <= 1'b1;
										active_q <= 1'b0;
										sector_q <= cursor_q;
										status_q <= ST_HOP_LIMIT;
									end else if (range_err) begin
										strobe_q <= 1'b1;
										active_q <= 1'b0;
										sector_q <= cursor_q;
										status_q <= ST_RANGE;
									end else begin
										// link read is under way; finish the hop next cycle
										if (bounded_q) begin
											bytes_left_q <= bytes_left_q - 48'(valid_c);
										end
										state_q <= S_HOP;
									end
								end
							end
							default: begin
								// unknown action: drop it
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_HOP: begin
					strobe_q <= 1'b1;
					sector_q <= sec_s1;
					offset_q <= off_s1;
					valid_q  <= valid_s1;
					last_q   <= next_last;
					status_q <= ST_OK;
					cursor_q <= rd_q;
					if (next_last) begin
						active_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe       = strobe_q;
	assign sector_index = sector_q;
	assign byte_offset  = offset_q;
	assign valid_bytes  = valid_q;
	assign is_last      = last_q;
	assign status       = status_q;

	a_hop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && strobe))
		else $error("hop did not finish in one busy cycle");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_HOP_LIMIT || status == ST_RANGE || status == ST_NO_WALK))
		|-> (is_last && byte_offset == '0 && valid_bytes == '0))
		else $error("error result not flagged as last");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_WRITE) |=> (strobe && status == ST_WRITE))
		else $error("write transaction gave no write result");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_START) |=> (!strobe && active_q))
		else $error("start transaction gave a result or no walk");

endmodule

### sim/fat_chain_walker_top_tb.sv
`timescale 1ns / 1ps

module fat_chain_walker_top_tb;
	import fcw_pkg::*;

	localparam int          TABLE_SLOTS = 4096;
	localparam int          SLACK_HOPS  = 4;
	localparam int          STALL_LIMIT = 1000;
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;

	typedef struct packed {
		logic [31:0] sector;
		logic [47:0] offset;
		logic [16:0] valid;
		logic        last;
		logic [2:0]  st;
	} hop_result_t;

	class chain_walk_scoreboard;
		logic [31:0]  link_tab [TABLE_SLOTS];
		bit           written [TABLE_SLOTS];
		logic [31:0]  cursor;
		int unsigned  hops;
		logic [47:0]  bytes_left;
		bit           bounded;
		bit           active;
		logic [12:0]  entries_reg;
		logic [4:0]   shift_reg;
		hop_result_t  hop_expected [$];
		int unsigned  mismatches;

		function new();
			cursor      = '0;
			hops        = 0;
			bytes_left  = '0;
			bounded     = 1'b0;
			active      = 1'b0;
			entries_reg = '0;
			shift_reg   = SHIFT_RESET;
			mismatches  = 0;
		endfunction

		function int unsigned entries_eff();
			return (entries_reg > TABLE_SLOTS) ? TABLE_SLOTS : 32'(entries_reg);
		endfunction

		function int unsigned shift_eff();
			if (shift_reg < SHIFT_MIN)
				return 32'(SHIFT_MIN);
			if (shift_reg > SHIFT_MAX)
				return 32'(SHIFT_MAX);
			return 32'(shift_reg);
		endfunction

		function void write_reg(logic idx, logic [ENTRIES_W-1:0] data);
			if (idx == REG_ENTRIES)
				entries_reg = data;
			else
				shift_reg = data[4:0];
		endfunction

		// true when the next hop would read a table slot never loaded
		function bit link_missing();
			return active && cursor != END_MARK && cursor != FREE_MARK
				&& hops + 1 <= entries_eff() + SLACK_HOPS
				&& cursor < entries_eff() && !written[cursor[11:0]];
		endfunction

		function hop_result_t result_of(logic [31:0] sec, logic [47:0] off, logic [16:0] vb,
				logic last, status_t st);
			hop_result_t r;
			r.sector = sec;
			r.offset = off;
			r.valid  = vb;
			r.last   = last;
			r.st     = st;
			return r;
		endfunction

		function hop_result_t predict_hop();
			int unsigned lim;
			int unsigned sh;
			logic [16:0] span;
			logic [16:0] vb;
			logic [47:0] off;
			logic [31:0] nxt;
			hop_result_t r;
			if (!active)
				return result_of('0, '0, '0, 1'b1, ST_NO_WALK);
			if (cursor == END_MARK || cursor == FREE_MARK) begin
				active = 1'b0;
				return result_of('0, '0, '0, 1'b1, ST_OK);
			end
			lim = entries_eff();
			sh  = shift_eff();
			hops++;
			if (hops > lim + SLACK_HOPS) begin
				active = 1'b0;
				return result_of(cursor, '0, '0, 1'b1, ST_HOP_LIMIT);
			end
			if (cursor >= lim) begin
				active = 1'b0;
				return result_of(cursor, '0, '0, 1'b1, ST_RANGE);
			end
			span = 17'd1 << sh;
			if (!bounded) begin
				vb = span;
			end else begin
				vb = (bytes_left < span) ? bytes_left[16:0] : span;
				bytes_left = bytes_left - 48'(vb);
			end
			off = ({16'd0, cursor} + 48'd1) << sh;
			nxt = link_tab[cursor[11:0]];
			r = result_of(cursor, off, vb, nxt == END_MARK || nxt == FREE_MARK, ST_OK);
			cursor = nxt;
			if (r.last)
				active = 1'b0;
			return r;
		endfunction

		function void note_command(logic [1:0] act, logic [11:0] idx, logic [31:0] val,
				logic [31:0] sec, logic [47:0] len);
			case (act)
				ACT_WRITE: begin
					link_tab[idx] = val;
					written[idx]  = 1'b1;
					hop_expected.push_back(result_of('0, '0, '0, 1'b0, ST_WRITE));
				end
				ACT_START: begin
					cursor     = sec;
					bytes_left = len;
					bounded    = (len != '0);
					hops       = 0;
					active     = 1'b1;
				end
				ACT_ADVANCE: begin
					hop_expected.push_back(predict_hop());
				end
				default: ;
			endcase
		endfunction

		function void check_result(hop_result_t got);
			hop_result_t want;
			if (hop_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result sector %h offset %h valid %h last %b st %0d",
						$realtime, got.sector, got.offset, got.valid, got.last, got.st);
				return;
			end
			want = hop_expected.pop_front();
			if (got.sector !== want.sector || got.offset !== want.offset
					|| got.valid !== want.valid || got.last !== want.last
					|| got.st !== want.st) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch, expected sector %h offset %h valid %h last %b st %0d",
						$realtime, want.sector, want.offset, want.valid, want.last, want.st);
					$display("%0t:           actual   sector %h offset %h valid %h last %b st %0d",
						$realtime, got.sector, got.offset, got.valid, got.last, got.st);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           action;
	logic [11:0]          entry_index;
	logic [31:0]          entry_value;
	logic [31:0]          start_sector;
	logic [47:0]          stream_length;
	logic                 strobe;
	logic [31:0]          sector_index;
	logic [47:0]          byte_offset;
	logic [16:0]          valid_bytes;
	logic                 is_last;
	logic [2:0]           status;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [ENTRIES_W-1:0] cfg_data;

	chain_walk_scoreboard sb;
	int burst_left;
	int cmd_count;
	int idle_cycles;

	fat_chain_walker_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.start_sector (start_sector),
		.stream_length(stream_length),
		.strobe       (strobe),
		.sector_index (sector_index),
		.byte_offset  (byte_offset),
		.valid_bytes  (valid_bytes),
		.is_last      (is_last),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin : monitor
		hop_result_t seen;
		if (arst_n) begin
			if (strobe) begin
				seen.sector = sector_index;
				seen.offset = byte_offset;
				seen.valid  = valid_bytes;
				seen.last   = is_last;
				seen.st     = status;
				sb.check_result(seen);
			end
			if (start && !busy)
				sb.note_command(action, entry_index, entry_value, start_sector, stream_length);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// entered at a falling edge; returns at the falling edge after the transaction
	task automatic issue(input logic [1:0] act, input logic [11:0] idx, input logic [31:0] val,
			input logic [31:0] sec, input logic [47:0] len);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		action        = act;
		entry_index   = idx;
		entry_value   = val;
		start_sector  = sec;
		stream_length = len;
		start         = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
		if (act != ACT_UNUSED)
			cmd_count++;
	endtask

	task automatic write_entry(input logic [11:0] idx, input logic [31:0] val);
		issue(ACT_WRITE, idx, val, $urandom, {16'($urandom), 32'($urandom)});
	endtask

	task automatic start_walk(input logic [31:0] sec, input logic [47:0] len);
		issue(ACT_START, 12'($urandom), $urandom, sec, len);
	endtask

	function automatic logic [31:0] rand_link(int unsigned lim);
		int k;
		k = $urandom_range(0, 99);
		if (lim > 0 && k < 55)
			return $urandom_range(0, lim - 1);
		if (k < 72)
			return END_MARK;
		if (k < 84)
			return FREE_MARK;
		if (k < 94)
			return lim + $urandom_range(0, 2);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_start(int unsigned lim);
		int k;
		k = $urandom_range(0, 99);
		if (lim > 0 && k < 70)
			return $urandom_range(0, lim - 1);
		if (k < 78)
			return END_MARK;
		if (k < 84)
			return FREE_MARK;
		if (k < 92)
			return lim + $urandom_range(0, 2);
		return $urandom;
	endfunction

	function automatic logic [47:0] pick_length(int unsigned sh);
		int k;
		k = $urandom_range(0, 99);
		if (k < 35)
			return '0;
		if (k < 75)
			return 48'($urandom_range(1, 5 << sh));
		if (k < 85)
			return 48'($urandom_range(1, 4)) << sh;
		return {16'($urandom), 32'($urandom)};
	endfunction

	// load any link the hop is about to follow, then advance
	task automatic advance();
		if (sb.link_missing())
			write_entry(sb.cursor[11:0], rand_link(sb.entries_eff()));
		issue(ACT_ADVANCE, 12'($urandom), $urandom, $urandom, {16'($urandom), 32'($urandom)});
	endtask

	task automatic walk_out();
		while (sb.active)
			advance();
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (sb.hop_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [ENTRIES_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int                   p;
		int                   n;
		int                   cap;
		int                   phase_end;
		int unsigned          lim;
		logic [ENTRIES_W-1:0] ent;
		logic [ENTRIES_W-1:0] shf;

		sb            = new();
		burst_left    = 0;
		cmd_count     = 0;
		idle_cycles   = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		action        = ACT_WRITE;
		entry_index   = '0;
		entry_value   = '0;
		start_sector  = '0;
		stream_length = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ENTRIES;
		cfg_data      = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no walk, out of range with an empty table, start on each marker
		advance();
		start_walk(32'd5, '0);
		advance();
		start_walk(END_MARK, 48'hFFFF_FFFF_FFFF);
		advance();
		start_walk(FREE_MARK, '0);
		advance();
		advance();
		issue(ACT_UNUSED, '1, '1, '1, '1);

		wait_idle();
		cfg_write(REG_ENTRIES, 13'd4);
		cfg_write(REG_SHIFT, 13'd0);
		write_entry(12'd0, 32'd1);
		write_entry(12'd1, 32'd2);
		write_entry(12'd2, END_MARK);
		write_entry(12'd3, 32'd3);
		write_entry(12'd4095, 32'hFFFF_FFFF);
		// bounded stream truncated in the third sector
		start_walk(32'd0, 48'd300);
		walk_out();
		// self loop runs into the hop limit
		start_walk(32'd3, '0);
		walk_out();

		wait_idle();
		cfg_write(REG_ENTRIES, 13'h1FFF);
		cfg_write(REG_SHIFT, 13'h1F);
		// stream of one byte, later sectors carry nothing
		start_walk(32'd1, 48'd1);
		walk_out();

		for (p = 0; cmd_count < 540; p++) begin
			case (p)
				0: begin ent = 13'd8;    shf = 13'd9;    end
				1: begin ent = 13'd1;    shf = 13'd16;   end
				2: begin ent = 13'd0;    shf = 13'd7;    end
				3: begin ent = 13'd16;   shf = 13'd31;   end
				4: begin ent = 13'd4096; shf = 13'd0;    end
				5: begin ent = 13'h1FFF; shf = 13'h1FEC; end
				6: begin ent = 13'd32;   shf = 13'h1F10; end
				7: begin ent = 13'd5;    shf = 13'd10;   end
				8: begin ent = 13'd40;   shf = 13'd8;    end
				default: begin
					ent = ($urandom_range(0, 9) < 8) ? 13'($urandom_range(0, 40))
						: 13'($urandom_range(0, 8191));
					shf = {8'($urandom), 5'($urandom_range(7, 16))};
				end
			endcase
			wait_idle();
			cfg_write(REG_ENTRIES, ent);
			cfg_write(REG_SHIFT, shf);
			lim = sb.entries_eff();
			if (lim <= 48)
				for (n = 0; n < lim; n++)
					write_entry(12'(n), rand_link(lim));
			phase_end = cmd_count + 60;
			while (cmd_count < phase_end) begin
				n = $urandom_range(0, 99);
				if (n < 3) begin
					issue(ACT_UNUSED, 12'($urandom), $urandom, $urandom, {16'($urandom), 32'($urandom)});
				end else if (n < 7) begin
					write_entry(12'($urandom), $urandom);
				end else begin
					start_walk(pick_start(lim), pick_length(sb.shift_eff()));
					// now and then drop the walk early so the next start restarts it
					cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 40;
					for (n = 0; n < cap && sb.active; n++)
						advance();
					if (!sb.active && $urandom_range(0, 9) == 0)
						advance();
				end
			end
		end

		start = 1'b0;
		while (sb.hop_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.mismatches == 0 && sb.hop_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hdl/fcw_pkg.sv
hdl/fat_chain_walker_top.sv
sim/fat_chain_walker_top_tb.sv
